// ===== hw/rtl/app_pkg.sv =====
`default_nettype none

package app_pkg;

   // Field widths of the request and response channels
   localparam int CHANNEL_W   = 2;
   localparam int RANK_W      = 1;
   localparam int BANK_W      = 3;
   localparam int ROW_FIELD_W = 16;
   localparam int CMD_W       = 2;
   localparam int QLEN_W      = 7;
   localparam int CTR_W       = 4;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_LEVEL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_WM     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_WM      = 2'd3;

   localparam logic [CTR_W-1:0]  CLOSE_LEVEL_RST = 4'd10;
   localparam logic [CTR_W-1:0]  OPEN_LEVEL_RST  = 4'd5;
   localparam logic [QLEN_W-1:0] HIGH_WM_RST     = 7'd40;
   localparam logic [QLEN_W-1:0] LOW_WM_RST      = 7'd20;

   // Default geometry
   localparam int DEF_NUM_CHANNELS = 4;
   localparam int DEF_NUM_RANKS    = 2;
   localparam int DEF_NUM_BANKS    = 8;
   localparam int DEF_ROW_BITS     = 16;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_COLUMN    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACTIVATE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PRECHARGE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESERVED  = 2'd3;

   // Request functions
   localparam logic FUNC_DRAIN   = 1'b0;
   localparam logic FUNC_REQUEST = 1'b1;

   localparam logic POLICY_OPEN  = 1'b0;
   localparam logic POLICY_CLOSE = 1'b1;

   localparam logic [CTR_W-1:0] CTR_MAX   = 4'd15;
   localparam logic [CTR_W-1:0] CTR_RESET = 4'd7;

   typedef struct packed {
      logic [CTR_W-1:0] ctr;
      logic             policy;
      logic             crow_valid;
   } entry_meta_type;

   localparam entry_meta_type META_RESET = '{
      ctr:        CTR_RESET,
      policy:     POLICY_OPEN,
      crow_valid: 1'b0
   };

   typedef struct packed {
      logic             hit;
      logic             ap;
      logic             record;
      logic             policy_after;
      logic [CTR_W-1:0] ctr;
   } policy_result_type;

   typedef struct packed {
      logic                   func;
      logic [CHANNEL_W-1:0]   channel;
      logic [RANK_W-1:0]      rank;
      logic [BANK_W-1:0]      bank;
      logic [ROW_FIELD_W-1:0] row;
      logic [ROW_FIELD_W-1:0] open_row;
      logic                   open_row_valid;
      logic [CMD_W-1:0]       next_cmd;
      logic [QLEN_W-1:0]      write_queue_len;
      logic [QLEN_W-1:0]      read_queue_len;
   } req_item_type;

   typedef struct packed {
      logic drain_mode;
      logic row_hit;
      logic policy_used;
      logic policy_after;
      logic auto_precharge;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== hw/rtl/app_if.sv =====
`default_nettype none

interface app_req_if;
   import app_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   func;
   logic [CHANNEL_W-1:0]   channel;
   logic [RANK_W-1:0]      rank;
   logic [BANK_W-1:0]      bank;
   logic [ROW_FIELD_W-1:0] row;
   logic [ROW_FIELD_W-1:0] open_row;
   logic                   open_row_valid;
   logic [CMD_W-1:0]       next_cmd;
   logic [QLEN_W-1:0]      write_queue_len;
   logic [QLEN_W-1:0]      read_queue_len;

   modport source (
      output valid, func, channel, rank, bank, row, open_row, open_row_valid,
             next_cmd, write_queue_len, read_queue_len,
      input  ready
   );

   modport sink (
      input  valid, func, channel, rank, bank, row, open_row, open_row_valid,
             next_cmd, write_queue_len, read_queue_len,
      output ready
   );
endinterface

interface app_rsp_if;
   logic valid;
   logic ready;
   logic drain_mode;
   logic row_hit;
   logic policy_used;
   logic policy_after;
   logic auto_precharge;

   modport source (
      output valid, drain_mode, row_hit, policy_used, policy_after, auto_precharge,
      input  ready
   );

   modport sink (
      input  valid, drain_mode, row_hit, policy_used, policy_after, auto_precharge,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/app_bank_table.sv =====
`default_nettype none

module app_bank_table #(
   parameter  int ENTRIES = 64,
   parameter  int ROW_W   = 16,
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        rd_en,
   input  wire  [IDX_W-1:0]           rd_idx,
   input  wire                        wr_en,
   input  wire  [IDX_W-1:0]           wr_idx,
   input  app_pkg::entry_meta_type    wr_meta,
   input  wire  [ROW_W-1:0]           wr_row,
   output app_pkg::entry_meta_type    rd_meta,
   output logic [ROW_W-1:0]           rd_row
);
   import app_pkg::*;

   localparam int META_W = $bits(entry_meta_type);
   localparam int WORD_W = META_W + ROW_W;

   logic [WORD_W-1:0]  mem [ENTRIES];
   logic [WORD_W-1:0]  rd_word_ff;

   // per-entry written flags: unwritten entries read as reset values
   logic [ENTRIES-1:0] written_ff, written_in;
   logic               rd_written_ff, rd_written_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;

   // last write, covers a read issued at the same edge as the write
   logic               fwd_valid_ff, fwd_valid_in;
   logic [IDX_W-1:0]   fwd_idx_ff, fwd_idx_in;
   entry_meta_type     fwd_meta_ff, fwd_meta_in;
   logic [ROW_W-1:0]   fwd_row_ff, fwd_row_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= {wr_meta, wr_row};
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_idx];
      end
   end

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_idx] = 1'b1;
      end
      rd_written_in = rd_en ? written_ff[rd_idx] : rd_written_ff;
      rd_idx_in     = rd_en ? rd_idx : rd_idx_ff;
      fwd_valid_in  = fwd_valid_ff | wr_en;
      fwd_idx_in    = wr_en ? wr_idx  : fwd_idx_ff;
      fwd_meta_in   = wr_en ? wr_meta : fwd_meta_ff;
      fwd_row_in    = wr_en ? wr_row  : fwd_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         written_ff   <= written_in;
         fwd_valid_ff <= fwd_valid_in;
      end
      rd_written_ff <= rd_written_in;
      rd_idx_ff     <= rd_idx_in;
      fwd_idx_ff    <= fwd_idx_in;
      fwd_meta_ff   <= fwd_meta_in;
      fwd_row_ff    <= fwd_row_in;
   end

   always_comb begin
      if (fwd_valid_ff && (fwd_idx_ff == rd_idx_ff)) begin
         rd_meta = fwd_meta_ff;
         rd_row  = fwd_row_ff;
      end else if (rd_written_ff) begin
         rd_meta = entry_meta_type'(rd_word_ff[WORD_W-1:ROW_W]);
         rd_row  = rd_word_ff[ROW_W-1:0];
      end else begin
         rd_meta = META_RESET;
         rd_row  = '0;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/app_policy_calc.sv =====
`default_nettype none

module app_policy_calc #(
   parameter int ROW_W = 16
) (
   input  app_pkg::entry_meta_type                  meta,
   input  wire  [ROW_W-1:0]                         crow,
   input  wire  [ROW_W-1:0]                         row,
   input  wire  [ROW_W-1:0]                         open_row,
   input  wire                                      open_row_valid,
   input  wire  [app_pkg::CMD_W-1:0]                next_cmd,
   input  wire  [app_pkg::CTR_W-1:0]                close_level,
   input  wire  [app_pkg::CTR_W-1:0]                open_level,
   output app_pkg::policy_result_type               result
);
   import app_pkg::*;

   always_comb begin
      result     = '0;
      result.ctr = meta.ctr;
      if (meta.policy == POLICY_OPEN) begin
         result.hit = open_row_valid && (open_row == row);
         if (!result.hit && (meta.ctr < CTR_MAX)) begin
            result.ctr = meta.ctr + 1'b1;
         end
         result.policy_after = (result.ctr >= close_level) ? POLICY_CLOSE : POLICY_OPEN;
      end else begin
         result.hit    = meta.crow_valid && (crow == row);
         result.record = (next_cmd == CMD_COLUMN);
         result.ap     = result.record;
         if (result.hit && (meta.ctr != '0)) begin
            result.ctr = meta.ctr - 1'b1;
         end
         result.policy_after = (result.ctr <= open_level) ? POLICY_OPEN : POLICY_CLOSE;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/app_drain_ctl.sv =====
`default_nettype none

module app_drain_ctl #(
   parameter  int NUM_CH   = 4,
   localparam int CH_IDX_W = (NUM_CH > 1) ? $clog2(NUM_CH) : 1
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              upd_en,
   input  wire  [app_pkg::CHANNEL_W-1:0]    channel,
   input  wire  [app_pkg::QLEN_W-1:0]       write_queue_len,
   input  wire  [app_pkg::QLEN_W-1:0]       read_queue_len,
   input  wire  [app_pkg::QLEN_W-1:0]       high_wm,
   input  wire  [app_pkg::QLEN_W-1:0]       low_wm,
   output logic                             cur_flag,
   output logic                             new_flag
);
   import app_pkg::*;

   logic [NUM_CH-1:0] flags_ff, flags_in;
   logic [CH_IDX_W-1:0] ch_idx;

   assign ch_idx = CH_IDX_W'(channel);

   always_comb begin
      cur_flag = flags_ff[ch_idx];
      // hysteresis holds while above the low mark; it starts above the high mark or on an empty read queue
      new_flag = cur_flag && (write_queue_len > low_wm);
      if (write_queue_len > high_wm) begin
         new_flag = 1'b1;
      end else if (read_queue_len == '0) begin
         new_flag = 1'b1;
      end
      flags_in = flags_ff;
      if (upd_en) begin
         flags_in[ch_idx] = new_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/adaptive_page_policy_unit.sv =====
// Adaptive open/close page policy and write-drain unit.
// req_ch (valid/ready) carries one request: func 0 updates the write-drain
// flag of a channel from its queue lengths, func 1 reports an issued DRAM
// request and updates that bank's miss counter, policy and closed row.
// rsp_ch (valid/ready) returns exactly one response per request, in order.
// csr_we/csr_index/csr_wdata write the thresholds and watermarks; write
// them only while no request is in flight.
// Flow: an accepted request is registered in the compute stage, and its
// response enters the response register when the compute stage moves on.
// Throughput: one request per cycle while responses are taken. The per-bank
// state lives in a single synchronous memory read at accept and written back
// when the compute stage moves on; a last-write bypass covers back-to-back
// requests on one bank. Stalls: the response register holds until taken;
// a request may still be taken while it waits, and the pipeline stops only
// when both the response register and the compute stage are full.
// Reset: synchronous, active high. Drain flags clear, thresholds and
// watermarks return to 10/5/40/20, and every bank entry reads as counter 7,
// open page, no closed row at once (per-entry written flags, no sweep).
`default_nettype none

module adaptive_page_policy_unit #(
   parameter int NUM_CHANNELS = app_pkg::DEF_NUM_CHANNELS,
   parameter int NUM_RANKS    = app_pkg::DEF_NUM_RANKS,
   parameter int NUM_BANKS    = app_pkg::DEF_NUM_BANKS,
   parameter int ROW_BITS     = app_pkg::DEF_ROW_BITS
) (
   input  wire                               clock,
   input  wire                               reset,
   app_req_if.sink                           req_ch,
   app_rsp_if.source                         rsp_ch,
   input  wire                               csr_we,
   input  wire  [app_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [app_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import app_pkg::*;

   // Only indexes the request fields can reach need storage
   localparam int EFF_CH  = (NUM_CHANNELS < (1 << CHANNEL_W)) ? NUM_CHANNELS : (1 << CHANNEL_W);
   localparam int EFF_RK  = (NUM_RANKS < (1 << RANK_W)) ? NUM_RANKS : (1 << RANK_W);
   localparam int EFF_BK  = (NUM_BANKS < (1 << BANK_W)) ? NUM_BANKS : (1 << BANK_W);
   localparam int ENTRIES = EFF_CH * EFF_RK * EFF_BK;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   // stored rows never exceed the request field
   localparam int ROW_W   = (ROW_BITS < ROW_FIELD_W) ? ROW_BITS : ROW_FIELD_W;

   // ---------------- configuration registers ----------------
   logic [CTR_W-1:0]  close_level_ff, close_level_in;
   logic [CTR_W-1:0]  open_level_ff, open_level_in;
   logic [QLEN_W-1:0] high_wm_ff, high_wm_in;
   logic [QLEN_W-1:0] low_wm_ff, low_wm_in;

   always_comb begin
      close_level_in = close_level_ff;
      open_level_in  = open_level_ff;
      high_wm_in     = high_wm_ff;
      low_wm_in      = low_wm_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CLOSE_LEVEL: close_level_in = csr_wdata[CTR_W-1:0];
            CSR_OPEN_LEVEL:  open_level_in  = csr_wdata[CTR_W-1:0];
            CSR_HIGH_WM:     high_wm_in     = csr_wdata[QLEN_W-1:0];
            CSR_LOW_WM:      low_wm_in      = csr_wdata[QLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         close_level_ff <= CLOSE_LEVEL_RST;
         open_level_ff  <= OPEN_LEVEL_RST;
         high_wm_ff     <= HIGH_WM_RST;
         low_wm_ff      <= LOW_WM_RST;
      end else begin
         close_level_ff <= close_level_in;
         open_level_ff  <= open_level_in;
         high_wm_ff     <= high_wm_in;
         low_wm_ff      <= low_wm_in;
      end
   end

   // ---------------- accept stage: decode, table read ----------------
   req_item_type      a_item;
   logic              a_ch_ok, a_bank_ok;
   logic [31:0]       a_idx_full;
   logic [IDX_W-1:0]  a_idx;
   logic              req_accept;
   logic              b_go;

   always_comb begin
      a_item.func            = req_ch.func;
      a_item.channel         = req_ch.channel;
      a_item.rank            = req_ch.rank;
      a_item.bank            = req_ch.bank;
      a_item.row             = req_ch.row;
      a_item.open_row        = req_ch.open_row;
      a_item.open_row_valid  = req_ch.open_row_valid;
      a_item.next_cmd        = req_ch.next_cmd;
      a_item.write_queue_len = req_ch.write_queue_len;
      a_item.read_queue_len  = req_ch.read_queue_len;

      a_ch_ok    = (32'(req_ch.channel) < EFF_CH);
      a_bank_ok  = (32'(req_ch.rank) < EFF_RK) && (32'(req_ch.bank) < EFF_BK);
      a_idx_full = (32'(req_ch.channel) * EFF_RK + 32'(req_ch.rank)) * EFF_BK
                 + 32'(req_ch.bank);
      a_idx      = (a_ch_ok && a_bank_ok) ? a_idx_full[IDX_W-1:0] : '0;
   end

   // ---------------- compute stage registers ----------------
   logic              b_valid_ff, b_valid_in;
   req_item_type      b_item_ff, b_item_in;
   logic              b_ch_ok_ff, b_ch_ok_in;
   logic              b_bank_ok_ff, b_bank_ok_in;
   logic [IDX_W-1:0]  b_idx_ff, b_idx_in;

   logic              out_valid_ff, out_valid_in;
   rsp_item_type      out_item_ff, out_item_in;

   // compute stage moves on when the response register is free or draining
   assign b_go       = b_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !b_valid_ff || b_go;
   assign req_accept = req_ch.valid && req_ch.ready;

   always_comb begin
      b_valid_in   = req_accept ? 1'b1 : (b_go ? 1'b0 : b_valid_ff);
      b_item_in    = req_accept ? a_item    : b_item_ff;
      b_ch_ok_in   = req_accept ? a_ch_ok   : b_ch_ok_ff;
      b_bank_ok_in = req_accept ? a_bank_ok : b_bank_ok_ff;
      b_idx_in     = req_accept ? a_idx     : b_idx_ff;
   end

   // ---------------- bank table ----------------
   entry_meta_type    rd_meta;
   logic [ROW_W-1:0]  rd_row;
   logic              wr_en;
   entry_meta_type    wr_meta;
   logic [ROW_W-1:0]  wr_row;

   app_bank_table #(
      .ENTRIES (ENTRIES),
      .ROW_W   (ROW_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_idx  (a_idx),
      .wr_en   (wr_en),
      .wr_idx  (b_idx_ff),
      .wr_meta (wr_meta),
      .wr_row  (wr_row),
      .rd_meta (rd_meta),
      .rd_row  (rd_row)
   );

   // ---------------- policy update ----------------
   policy_result_type pol;

   app_policy_calc #(
      .ROW_W (ROW_W)
   ) u_policy (
      .meta           (rd_meta),
      .crow           (rd_row),
      .row            (b_item_ff.row[ROW_W-1:0]),
      .open_row       (b_item_ff.open_row[ROW_W-1:0]),
      .open_row_valid (b_item_ff.open_row_valid),
      .next_cmd       (b_item_ff.next_cmd),
      .close_level    (close_level_ff),
      .open_level     (open_level_ff),
      .result         (pol)
   );

   // ---------------- drain flags ----------------
   logic drain_upd;
   logic drain_cur;
   logic drain_new;

   assign drain_upd = b_go && b_ch_ok_ff && (b_item_ff.func == FUNC_DRAIN);

   app_drain_ctl #(
      .NUM_CH (EFF_CH)
   ) u_drain (
      .clock           (clock),
      .reset           (reset),
      .upd_en          (drain_upd),
      .channel         (b_item_ff.channel),
      .write_queue_len (b_item_ff.write_queue_len),
      .read_queue_len  (b_item_ff.read_queue_len),
      .high_wm         (high_wm_ff),
      .low_wm          (low_wm_ff),
      .cur_flag        (drain_cur),
      .new_flag        (drain_new)
   );

   // ---------------- write-back and response ----------------
   rsp_item_type rsp_d;

   always_comb begin
      wr_en = b_go && b_ch_ok_ff && b_bank_ok_ff && (b_item_ff.func == FUNC_REQUEST);

      wr_meta.ctr        = pol.ctr;
      wr_meta.policy     = pol.policy_after;
      // column command in close mode records the row it auto-closes
      wr_meta.crow_valid = pol.record ? 1'b1 : rd_meta.crow_valid;
      wr_row             = pol.record ? b_item_ff.row[ROW_W-1:0] : rd_row;

      rsp_d = '0;
      if (b_ch_ok_ff) begin
         if (b_item_ff.func == FUNC_DRAIN) begin
            rsp_d.drain_mode = drain_new;
         end else begin
            rsp_d.drain_mode = drain_cur;
            if (b_bank_ok_ff) begin
               rsp_d.row_hit        = pol.hit;
               rsp_d.policy_used    = rd_meta.policy;
               rsp_d.policy_after   = pol.policy_after;
               rsp_d.auto_precharge = pol.ap;
            end
         end
      end

      out_valid_in = b_go ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
      out_item_in  = b_go ? rsp_d : out_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
      b_item_ff    <= b_item_in;
      b_ch_ok_ff   <= b_ch_ok_in;
      b_bank_ok_ff <= b_bank_ok_in;
      b_idx_ff     <= b_idx_in;
      out_item_ff  <= out_item_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.drain_mode     = out_item_ff.drain_mode;
   assign rsp_ch.row_hit        = out_item_ff.row_hit;
   assign rsp_ch.policy_used    = out_item_ff.policy_used;
   assign rsp_ch.policy_after   = out_item_ff.policy_after;
   assign rsp_ch.auto_precharge = out_item_ff.auto_precharge;

endmodule

`default_nettype wire
